>>> hw/rtl/bgr_pkg.sv
// Shared types, constants and the 3x5 font table for the glyph-to-rectangle generator.
`timescale 1ns / 1ps

package bgr_pkg;

   localparam int GLYPH_COUNT = 64;
   localparam int GLYPH_IDX_W = $clog2(GLYPH_COUNT);
   localparam int PIX_BITS    = 15;
   localparam int CURSOR_W    = 20;
   localparam int COORD_W     = 16;
   localparam int SCALE_W     = 8;
   localparam int ENTRY_W     = 18;

   localparam logic [6:0] CODE_SPACE      = 7'h20;
   localparam logic [6:0] CODE_FIRST_GLYPH = 7'h21;
   localparam logic [6:0] CODE_LOWER_A    = 7'h61;
   localparam logic [6:0] CASE_OFFSET     = 7'd32;
   localparam logic [CURSOR_W-1:0] SPACE_ADVANCE = 20'd8;

   // Request mode: begin a string, or draw one character.
   typedef enum logic {
      MODE_BEGIN = 1'b0,
      MODE_CHAR  = 1'b1
   } req_mode_type;

   // Bits 17:16 width, bits 14:0 pixels with the top-left pixel in bit 14.
   // Entry k draws code 0x21+k.
   localparam logic [ENTRY_W-1:0] GLYPH_ROM [GLYPH_COUNT] = '{
      18'h12482, 18'h35A00, 18'h35555, 18'h33C9E, 18'h352A5, 18'h32AAB, 18'h12400, 18'h32922,
      18'h3224A, 18'h30AA8, 18'h305D0, 18'h10012, 18'h301C0, 18'h10002, 18'h312A4, 18'h32B6A,
      18'h32C97, 18'h362A7, 18'h3628E, 18'h329D2, 18'h3798E, 18'h329AA, 18'h37292, 18'h32AAA,
      18'h32ACA, 18'h10410, 18'h10412, 18'h30510, 18'h30E38, 18'h30450, 18'h32282, 18'h3FFFF,
      18'h32BED, 18'h36BAE, 18'h33923, 18'h36B6E, 18'h379A7, 18'h379A4, 18'h3392B, 18'h35BED,
      18'h37497, 18'h3326A, 18'h34BAD, 18'h34927, 18'h35F6D, 18'h37B6D, 18'h37B6F, 18'h36BA4,
      18'h32B59, 18'h36BAD, 18'h3388E, 18'h37492, 18'h35B6A, 18'h35B52, 18'h35B7D, 18'h35AAD,
      18'h35A92, 18'h372A7, 18'h36926, 18'h34889, 18'h3324B, 18'h32A00, 18'h30007, 18'h00000
   };

   // One character's worth of drawing work handed to the square emitter.
   typedef struct packed {
      logic [PIX_BITS-1:0] pixels;
      logic [CURSOR_W-1:0] cur_half;
      logic [COORD_W-1:0]  top;
      logic [SCALE_W-1:0]  scale;
   } bgr_work_type;

endpackage

>>> hw/rtl/bgr_emit.sv
// Square emitter: walks the lit pixels of one glyph and drives the result register.
`timescale 1ns / 1ps

module bgr_emit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load_valid,
   input  bgr_pkg::bgr_work_type         load_work,
   output logic                          load_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [bgr_pkg::COORD_W-1:0] rsp_rect_x,
   output logic signed [bgr_pkg::COORD_W-1:0] rsp_rect_y,
   output logic [bgr_pkg::SCALE_W-1:0]   rsp_rect_size,
   output logic                          rsp_last
);
   import bgr_pkg::*;

   logic [PIX_BITS-1:0] pix_ff, pix_in;
   logic [CURSOR_W-1:0] cur_ff;
   logic [COORD_W-1:0]  top_ff;
   logic [SCALE_W-1:0]  scale_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0]  rect_x_ff, rect_x_in;
   logic [COORD_W-1:0]  rect_y_ff, rect_y_in;
   logic [SCALE_W-1:0]  size_ff;
   logic                last_ff, last_in;

   logic                busy, out_free, fire;
   logic [2:0]          sel_row;
   logic [1:0]          sel_col;
   logic [PIX_BITS-1:0] sel_mask, rest;
   logic [10:0]         col_off, row_off;
   logic [CURSOR_W:0]   pos, pos_rnd;

   assign busy     = |pix_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign fire     = busy && out_free;

   // Pick the first lit pixel in row-major order, top-left first.
   always_comb begin
      sel_row  = '0;
      sel_col  = '0;
      sel_mask = '0;
      for (int p = PIX_BITS - 1; p >= 0; p--) begin
         if (pix_ff[PIX_BITS-1-p]) begin
            sel_row  = 3'(p / 3);
            sel_col  = 2'(p % 3);
            sel_mask = PIX_BITS'(1 << (PIX_BITS - 1 - p));
         end
      end
   end

   assign rest       = pix_ff & ~sel_mask;
   assign load_ready = !busy || (fire && (rest == '0));

   always_comb begin
      case (sel_col)
         2'd0:    col_off = '0;
         2'd1:    col_off = {2'b00, scale_ff, 1'b0};
         default: col_off = {1'b0, scale_ff, 2'b00};
      endcase
   end

   // Half-pixel position, then halve with truncation toward zero.
   assign pos       = {cur_ff[CURSOR_W-1], cur_ff} + {10'd0, col_off};
   assign pos_rnd   = pos + {{CURSOR_W{1'b0}}, pos[CURSOR_W]};
   assign row_off   = 11'({8'd0, sel_row} * {3'd0, scale_ff});
   assign rect_x_in = pos_rnd[COORD_W:1];
   assign rect_y_in = top_ff + {5'd0, row_off};
   assign last_in   = (rest == '0);

   always_comb begin
      pix_in = pix_ff;
      if (load_valid && load_ready) begin
         pix_in = load_work.pixels;
      end else if (fire) begin
         pix_in = rest;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pix_ff       <= pix_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_valid && load_ready) begin
         cur_ff   <= load_work.cur_half;
         top_ff   <= load_work.top;
         scale_ff <= load_work.scale;
      end
      if (fire) begin
         rect_x_ff <= rect_x_in;
         rect_y_ff <= rect_y_in;
         size_ff   <= scale_ff;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rect_x    = rect_x_ff;
   assign rsp_rect_y    = rect_y_ff;
   assign rsp_rect_size = size_ff;
   assign rsp_last      = last_ff;

endmodule

>>> hw/rtl/bitmap_glyph_to_rectangles.sv
// Top level: text to squares with a 3x5 bitmap font.
`timescale 1ns / 1ps

// Usage
// - req channel: mode 0 is a begin transaction that latches start_x, start_y
//   and scale and puts the cursor at the origin; mode 1 carries one character.
// - rsp channel: one square per transaction (rect_x, rect_y, rect_size), with
//   last set on the final square of a character. Characters with no lit
//   pixels (space, blank glyph, control and high codes) give no transaction.
// - Path: an accepted character's pixels are registered in the emitter, and
//   each square is then registered in the result register before it is offered.
// - Throughput: one square per cycle from the single square emitter while the
//   result register is not stalled, so a character with n lit pixels gives n
//   squares (1 to 15); items that draw nothing never occupy the emitter. The next
//   character is accepted in the cycle its predecessor's last square leaves the emitter.
// - Stall: while rsp_ready is low a full result register holds and the emitter
//   waits; req_ready drops once the emitter holds pending pixels.
// - Reset: cursor and line top clear to zero, scale becomes one, and any
//   pending squares are dropped.
module bitmap_glyph_to_rectangles (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_mode,
   input  logic signed [bgr_pkg::COORD_W-1:0]  req_start_x,
   input  logic signed [bgr_pkg::COORD_W-1:0]  req_start_y,
   input  logic [bgr_pkg::SCALE_W-1:0]         req_scale,
   input  logic [7:0]                          req_char_code,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [bgr_pkg::COORD_W-1:0]  rsp_rect_x,
   output logic signed [bgr_pkg::COORD_W-1:0]  rsp_rect_y,
   output logic [bgr_pkg::SCALE_W-1:0]         rsp_rect_size,
   output logic                                rsp_last
);
   import bgr_pkg::*;

   logic [CURSOR_W-1:0] cursor_ff, cursor_in;
   logic [COORD_W-1:0]  line_top_ff, line_top_in;
   logic [SCALE_W-1:0]  font_scale_ff, font_scale_in;

   logic                accept;
   logic                printable, is_space, is_glyph;
   logic [6:0]          folded, idx7;
   logic [ENTRY_W-1:0]  entry;
   logic [1:0]          glyph_w;
   logic [9:0]          shift;
   logic [CURSOR_W-1:0] cur_pre;
   bgr_work_type        work;

   assign accept = req_valid && req_ready;

   // Fold lower case and the codes above it onto the upper-case glyphs.
   assign printable = !req_char_code[7] && (req_char_code[6:0] >= CODE_SPACE);
   assign folded    = (req_char_code[6:0] >= CODE_LOWER_A) ?
                      (req_char_code[6:0] - CASE_OFFSET) : req_char_code[6:0];
   assign is_space  = (folded == CODE_SPACE);
   assign is_glyph  = printable && !is_space;
   assign idx7      = folded - CODE_FIRST_GLYPH;

   always_comb begin
      entry = '0;
      if (is_glyph && (int'(idx7) < GLYPH_COUNT)) begin
         entry = GLYPH_ROM[idx7[GLYPH_IDX_W-1:0]];
      end
   end

   // Narrow glyphs are centred: pull the cursor left by (3-width) half-scales.
   assign glyph_w = entry[ENTRY_W-1:ENTRY_W-2];
   assign shift   = {8'd0, 2'd3 - glyph_w} * {2'd0, font_scale_ff};
   assign cur_pre = cursor_ff - {10'd0, shift};

   always_comb begin
      cursor_in     = cursor_ff;
      line_top_in   = line_top_ff;
      font_scale_in = font_scale_ff;
      if (accept) begin
         if (req_mode == MODE_BEGIN) begin
            cursor_in     = {{3{req_start_x[COORD_W-1]}}, req_start_x, 1'b0};
            line_top_in   = req_start_y;
            font_scale_in = req_scale;
         end else if (is_glyph) begin
            cursor_in = cur_pre + {9'd0, font_scale_ff, 3'b000} - {10'd0, shift};
         end else if (printable) begin
            cursor_in = cursor_ff + SPACE_ADVANCE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff     <= '0;
         line_top_ff   <= '0;
         font_scale_ff <= SCALE_W'(1);
      end else begin
         cursor_ff     <= cursor_in;
         line_top_ff   <= line_top_in;
         font_scale_ff <= font_scale_in;
      end
   end

   // Begin and blank transactions hand over no pixels and so emit nothing.
   assign work.pixels   = (req_mode == MODE_CHAR) ? entry[PIX_BITS-1:0] : '0;
   assign work.cur_half = cur_pre;
   assign work.top      = line_top_ff;
   assign work.scale    = font_scale_ff;

   bgr_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .load_valid    (accept),
      .load_work     (work),
      .load_ready    (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_rect_x    (rsp_rect_x),
      .rsp_rect_y    (rsp_rect_y),
      .rsp_rect_size (rsp_rect_size),
      .rsp_last      (rsp_last)
   );

`ifndef SYNTHESIS
   a_reset_state: assert property (@(posedge clock)
      reset |=> (cursor_ff == '0) && (line_top_ff == '0) && (font_scale_ff == SCALE_W'(1))
      && !rsp_valid)
      else $error("state not cleared by reset");

   a_begin_latch: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_mode == MODE_BEGIN)) |=> (line_top_ff == $past(req_start_y))
      && (font_scale_ff == $past(req_scale)))
      else $error("begin transaction not latched");

   a_no_gap_in_char: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> rsp_valid)
      else $error("gap inside a character's squares");
`endif

endmodule

>>> tb/glyph_square_checker.sv
// Checker that predicts the squares for each request and compares them with the results.
`timescale 1ns / 1ps

module glyph_square_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic                                req_mode,
   input  logic signed [bgr_pkg::COORD_W-1:0]  req_start_x,
   input  logic signed [bgr_pkg::COORD_W-1:0]  req_start_y,
   input  logic [bgr_pkg::SCALE_W-1:0]         req_scale,
   input  logic [7:0]                          req_char_code,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [bgr_pkg::COORD_W-1:0]  rsp_rect_x,
   input  logic signed [bgr_pkg::COORD_W-1:0]  rsp_rect_y,
   input  logic [bgr_pkg::SCALE_W-1:0]         rsp_rect_size,
   input  logic                                rsp_last,
   output int                                  fail_count,
   output int                                  squares_owed
);
   import bgr_pkg::*;

   localparam logic [7:0] CH_SPACE       = 8'h20;
   localparam logic [7:0] CH_FIRST_GLYPH = 8'h21;
   localparam logic [7:0] CH_LOWER_A     = 8'h61;
   localparam logic [7:0] CH_HIGH        = 8'h80;
   localparam logic [7:0] CASE_SHIFT     = 8'd32;
   localparam int         FONT_SIZE      = 64;

   // Width in bits 17:16, pixels in 14:0 with the top-left pixel in bit 14.
   localparam logic [17:0] FONT_TABLE [FONT_SIZE] = '{
      18'h12482, 18'h35A00, 18'h35555, 18'h33C9E, 18'h352A5, 18'h32AAB, 18'h12400, 18'h32922,
      18'h3224A, 18'h30AA8, 18'h305D0, 18'h10012, 18'h301C0, 18'h10002, 18'h312A4, 18'h32B6A,
      18'h32C97, 18'h362A7, 18'h3628E, 18'h329D2, 18'h3798E, 18'h329AA, 18'h37292, 18'h32AAA,
      18'h32ACA, 18'h10410, 18'h10412, 18'h30510, 18'h30E38, 18'h30450, 18'h32282, 18'h3FFFF,
      18'h32BED, 18'h36BAE, 18'h33923, 18'h36B6E, 18'h379A7, 18'h379A4, 18'h3392B, 18'h35BED,
      18'h37497, 18'h3326A, 18'h34BAD, 18'h34927, 18'h35F6D, 18'h37B6D, 18'h37B6F, 18'h36BA4,
      18'h32B59, 18'h36BAD, 18'h3388E, 18'h37492, 18'h35B6A, 18'h35B52, 18'h35B7D, 18'h35AAD,
      18'h35A92, 18'h372A7, 18'h36926, 18'h34889, 18'h3324B, 18'h32A00, 18'h30007, 18'h00000
   };

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic [7:0]  size;
      logic        last;
   } square_type;

   square_type  squares_due[$];
   logic [19:0] pen_half;
   logic [15:0] pen_top;
   logic [7:0]  pen_scale;

   task automatic predict_char(input logic [7:0] code);
      logic [7:0]  c;
      logic [17:0] entry;
      logic [14:0] pixels;
      logic [19:0] shift;
      int          idx;
      int          cur;
      int          pos;
      int          tx;
      square_type  sq;
      square_type  glyph_squares[$];
      if (code >= CH_HIGH || code < CH_SPACE) return;
      c = (code >= CH_LOWER_A) ? code - CASE_SHIFT : code;
      if (c == CH_SPACE) begin
         pen_half = pen_half + 20'd8;
         return;
      end
      idx    = int'(c) - int'(CH_FIRST_GLYPH);
      entry  = (idx < FONT_SIZE) ? FONT_TABLE[idx] : '0;
      pixels = entry[14:0];
      // pre-shift narrow glyphs so they sit centred in the 3-pixel cell
      shift  = 20'((3 - int'(entry[17:16])) * int'(pen_scale));
      pen_half = pen_half - shift;
      cur = int'($signed(pen_half));
      for (int p = 0; p < 15; p++) begin
         if (pixels[14 - p]) begin
            pos     = cur + 2 * (p % 3) * int'(pen_scale);
            tx      = pos / 2;
            sq.x    = 16'(tx);
            sq.y    = pen_top + 16'((p / 3) * int'(pen_scale));
            sq.size = pen_scale;
            sq.last = 1'b0;
            glyph_squares.push_back(sq);
         end
      end
      if (glyph_squares.size() > 0) glyph_squares[glyph_squares.size() - 1].last = 1'b1;
      foreach (glyph_squares[i]) squares_due.push_back(glyph_squares[i]);
      pen_half = pen_half + 20'(8 * int'(pen_scale)) - shift;
   endtask

   task automatic check_square();
      square_type got;
      square_type want;
      got = '{rsp_rect_x, rsp_rect_y, rsp_rect_size, rsp_last};
      if (squares_due.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t: unexpected square x=%0d y=%0d size=%0d last=%0b", $realtime,
                     $signed(got.x), $signed(got.y), got.size, got.last);
      end else begin
         want = squares_due.pop_front();
         if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("%0t: square mismatch: expected x=%0d y=%0d size=%0d last=%0b",
                        $realtime, $signed(want.x), $signed(want.y), want.size, want.last);
               $display("%0t: square mismatch: got      x=%0d y=%0d size=%0d last=%0b",
                        $realtime, $signed(got.x), $signed(got.y), got.size, got.last);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         squares_due.delete();
         pen_half  = '0;
         pen_top   = '0;
         pen_scale = 8'd1;
      end else begin
         if (rsp_valid && rsp_ready) check_square();
         if (req_valid && req_ready) begin
            if (req_mode == MODE_BEGIN) begin
               pen_half  = {{3{req_start_x[15]}}, req_start_x, 1'b0};
               pen_top   = req_start_y;
               pen_scale = req_scale;
            end else begin
               predict_char(req_char_code);
            end
         end
      end
      squares_owed <= squares_due.size();
   end

endmodule

>>> tb/bitmap_glyph_to_rectangles_tb.sv
// Top of the bench: clock, reset, request stimulus, result back-pressure and the verdict.
`timescale 1ns / 1ps

module bitmap_glyph_to_rectangles_tb;
   import bgr_pkg::*;

   typedef enum int {
      RX_OPEN,
      RX_RANDOM,
      RX_PERIODIC
   } rx_pattern_type;

   logic               clock         = 1'b0;
   logic               reset         = 1'b1;
   logic               req_valid     = 1'b0;
   logic               req_ready;
   logic               req_mode      = 1'b0;
   logic signed [15:0] req_start_x   = '0;
   logic signed [15:0] req_start_y   = '0;
   logic [7:0]         req_scale     = 8'd1;
   logic [7:0]         req_char_code = '0;
   logic               rsp_valid;
   logic               rsp_ready     = 1'b0;
   logic signed [15:0] rsp_rect_x;
   logic signed [15:0] rsp_rect_y;
   logic [7:0]         rsp_rect_size;
   logic               rsp_last;

   int             fail_count;
   int             squares_owed;
   int             chars_sent;
   int             burst_left;
   rx_pattern_type rx_pattern;
   int unsigned    rx_period;
   int unsigned    rx_low;
   int unsigned    rx_left;

   bitmap_glyph_to_rectangles u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_start_x   (req_start_x),
      .req_start_y   (req_start_y),
      .req_scale     (req_scale),
      .req_char_code (req_char_code),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_rect_x    (rsp_rect_x),
      .rsp_rect_y    (rsp_rect_y),
      .rsp_rect_size (rsp_rect_size),
      .rsp_last      (rsp_last)
   );

   glyph_square_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_start_x   (req_start_x),
      .req_start_y   (req_start_y),
      .req_scale     (req_scale),
      .req_char_code (req_char_code),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_rect_x    (rsp_rect_x),
      .rsp_rect_y    (rsp_rect_y),
      .rsp_rect_size (rsp_rect_size),
      .rsp_last      (rsp_last),
      .fail_count    (fail_count),
      .squares_owed  (squares_owed)
   );

   always #5 clock = ~clock;

   // Result side: switch between open, random and periodic stall patterns.
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_pattern = rx_pattern_type'($urandom_range(0, 2));
         rx_period  = $urandom_range(3, 9);
         rx_low     = $urandom_range(1, rx_period - 1);
         rx_left    = $urandom_range(32, 160);
      end
      rx_left--;
      case (rx_pattern)
         RX_OPEN:   rsp_ready <= 1'b1;
         RX_RANDOM: rsp_ready <= ($urandom_range(0, 2) != 0);
         default:   rsp_ready <= ((rx_left % rx_period) >= rx_low);
      endcase
   end

   task automatic send_req(input req_mode_type mode, input logic [15:0] sx,
                           input logic [15:0] sy, input logic [7:0] sc,
                           input logic [7:0] code);
      int gap;
      // start a new burst, optionally after an idle gap
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_start_x   <= sx;
      req_start_y   <= sy;
      req_scale     <= sc;
      req_char_code <= code;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      chars_sent++;
   endtask

   task automatic send_begin(input logic [15:0] sx, input logic [15:0] sy, input logic [7:0] sc);
      send_req(MODE_BEGIN, sx, sy, sc, 8'($urandom));
   endtask

   task automatic send_char(input logic [7:0] code);
      send_req(MODE_CHAR, 16'($urandom), 16'($urandom), 8'($urandom), code);
   endtask

   function automatic logic [7:0] pick_code();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return 8'($urandom_range(8'h21, 8'h7f));
      if (r < 90) return 8'h20;
      if (r < 95) return 8'($urandom_range(8'h00, 8'h1f));
      return 8'($urandom_range(8'h80, 8'hff));
   endfunction

   function automatic logic [15:0] pick_coord();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return 16'($urandom);
      if (r < 8) return 16'($urandom_range(0, 400) - 200);
      case ($urandom_range(0, 3))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return 16'h0000;
         default: return 16'hffff;
      endcase
   endfunction

   function automatic logic [7:0] pick_scale();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return 8'($urandom_range(1, 8));
      if (r < 9) return 8'($urandom);
      case ($urandom_range(0, 2))
         0:       return 8'd0;
         1:       return 8'd1;
         default: return 8'd255;
      endcase
   endfunction

   initial begin
      int n;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // character straight out of reset uses the reset cursor and scale
      send_char(8'h41);
      send_begin(16'h0000, 16'h0000, 8'd1);
      send_char(8'h21);   // narrow glyph
      send_char(8'h60);   // blank glyph, advances without drawing
      send_char(8'h20);
      send_char(8'h7f);
      send_char(8'h7b);
      send_char(8'h7c);
      send_char(8'h7d);
      send_char(8'h7e);
      send_char(8'h61);
      send_char(8'h1f);
      send_char(8'h80);
      send_char(8'hff);
      send_char(8'h00);
      send_begin(16'h8000, 16'h7fff, 8'd255);
      send_char(8'h40);   // every pixel lit
      send_char(8'h57);
      send_begin(16'h7fff, 16'h8000, 8'd0);
      send_char(8'h40);
      send_begin(16'hffff, 16'hffff, 8'd128);
      send_char(8'h21);
      send_char(8'h25);

      // long line at the largest scale runs the cursor past its wrap point
      send_begin(16'h7fff - 16'($urandom_range(0, 15)), pick_coord(), 8'd255);
      repeat (250)
         send_char(8'($urandom_range(8'h41, 8'h5a)) | ($urandom_range(0, 1) ? 8'h20 : 8'h00));

      while (chars_sent < 420) begin
         if ($urandom_range(0, 9) != 0) send_begin(pick_coord(), pick_coord(), pick_scale());
         n = $urandom_range(0, 12);
         repeat (n) send_char(pick_code());
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (squares_owed != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && squares_owed == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/bgr_pkg.sv
hw/rtl/bgr_emit.sv
hw/rtl/bitmap_glyph_to_rectangles.sv
tb/glyph_square_checker.sv
tb/bitmap_glyph_to_rectangles_tb.sv
